// File: rtl/matt_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// Multi-alarm timer table package
// Shared sizes, codes and the layout of one table entry.
// -----------------------------------------------------------------------------
package matt_pkg;

  localparam int NumTimers = 16;
  localparam int IdxBits   = $clog2(NumTimers);
  localparam int CntBits   = $clog2(NumTimers + 1);
  localparam int TimeBits  = 32;
  localparam int IdBits    = 32;

  typedef logic [TimeBits-1:0] time_t;
  typedef logic [IdBits-1:0]   id_t;
  typedef logic [IdxBits-1:0]  idx_t;

  localparam time_t TimeMax = '1;

  typedef enum logic [1:0] {
    CmdSet    = 2'd0,
    CmdDelete = 2'd1,
    CmdExpire = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    KindStored  = 3'd0,
    KindFull    = 3'd1,
    KindRemoved = 3'd2,
    KindFired   = 3'd3,
    KindDone    = 3'd4
  } result_kind_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDone
  } state_e;

  // One row of the entry memory.
  typedef struct packed {
    id_t   owner;
    time_t period;
    time_t remaining;
  } entry_t;

  // One result transaction as it sits in the output register.
  typedef struct packed {
    result_kind_e kind;
    idx_t         index;
    id_t          fired_id;
    logic         prog;
    time_t        value;
    logic         last;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/matt_ram.sv
`default_nettype none
// -----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port; read data is registered.
// -----------------------------------------------------------------------------
module matt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire [Width-1:0]         wdata_i,
  input  wire                     re_i,
  input  wire [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]        rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: rtl/multi_alarm_timer_table_top.sv
`default_nettype none
// -----------------------------------------------------------------------------
// Multi-alarm timer table
// Alarm entries in a RAM, armed bits in flops, and a sequencer that serves
// set, delete and expiry commands and reports fired alarms and the new sleep.
// -----------------------------------------------------------------------------
// Channel   Direction  Handshake                    Payload
// command   in         start & !busy                cmd, timer_id, start_delay,
//                                                   period, handle
// result    out        result_valid_o (one cycle)   result_kind, entry_index,
//                                                   fired_id, program_alarm,
//                                                   alarm_value, last
//
// For set and delete, the result appears in the next cycle and a new command
// is taken in that same cycle. An expiry keeps busy high until its summary is
// registered: the sequencer reads one entry per cycle from the single read port
// of the entry RAM and writes back each kept entry in the next cycle.
// Reset clears all armed bits at once, so no clearing pass is needed.
// Results cannot be stalled; each is shown for exactly one cycle.
// -----------------------------------------------------------------------------
module multi_alarm_timer_table_top
  import matt_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  cmd_i,
  input  wire  [31:0] timer_id_i,
  input  wire  [31:0] start_delay_i,
  input  wire  [31:0] period_i,
  input  wire  [3:0]  handle_i,
  output logic        result_valid_o,
  output logic [2:0]  result_kind_o,
  output logic [3:0]  entry_index_o,
  output logic [31:0] fired_id_o,
  output logic        program_alarm_o,
  output logic [31:0] alarm_value_o,
  output logic        last_o
);

  state_e                 state_q, state_d;
  logic [NumTimers-1:0]   armed_q, armed_d;
  time_t                  sleep_q, sleep_d;
  time_t                  next_q, next_d;
  logic [CntBits-1:0]     cnt_q, cnt_d;
  logic                   pipe_vld_q, pipe_vld_d;
  idx_t                   pipe_idx_q, pipe_idx_d;
  logic                   out_vld_q, out_vld_d;
  result_t                out_q, out_d;

  logic                   mem_we, rd_en;
  idx_t                   mem_waddr;
  entry_t                 mem_wdata, rdata;

  logic                   have_free;
  idx_t                   free_slot;
  time_t                  cand;
  logic                   keep;

  matt_ram #(
    .Width($bits(entry_t)),
    .Depth(NumTimers)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (rd_en),
    .raddr_i(cnt_q[IdxBits-1:0]),
    .rdata_o(rdata)
  );

  // Lowest free entry.
  always_comb begin
    have_free = 1'b0;
    free_slot = '0;
    for (int i = NumTimers - 1; i >= 0; i--) begin
      if (!armed_q[i]) begin
        have_free = 1'b1;
        free_slot = IdxBits'(i);
      end
    end
  end

  assign busy = (state_q != StIdle);

  always_comb begin
    state_d    = state_q;
    armed_d    = armed_q;
    sleep_d    = sleep_q;
    next_d     = next_q;
    cnt_d      = cnt_q;
    pipe_vld_d = 1'b0;
    pipe_idx_d = cnt_q[IdxBits-1:0];
    out_vld_d  = 1'b0;
    out_d      = '0;
    mem_we     = 1'b0;
    mem_waddr  = pipe_idx_q;
    mem_wdata  = rdata;
    rd_en      = 1'b0;
    cand       = rdata.period;
    keep       = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (start) begin
          unique case (cmd_e'(cmd_i))
            CmdSet: begin
              out_vld_d  = 1'b1;
              out_d.last = 1'b1;
              if (have_free) begin
                armed_d[free_slot] = 1'b1;
                mem_we      = 1'b1;
                mem_waddr   = free_slot;
                mem_wdata   = '{owner: timer_id_i, period: period_i,
                                remaining: start_delay_i};
                out_d.kind  = KindStored;
                out_d.index = free_slot;
                if (sleep_q > start_delay_i) begin
                  sleep_d     = start_delay_i;
                  out_d.prog  = 1'b1;
                  out_d.value = start_delay_i;
                end
              end else begin
                out_d.kind = KindFull;
              end
            end
            CmdDelete: begin
              if (32'(handle_i) < NumTimers) begin
                armed_d[handle_i[IdxBits-1:0]] = 1'b0;
              end
              out_vld_d   = 1'b1;
              out_d.kind  = KindRemoved;
              out_d.index = handle_i;
              out_d.last  = 1'b1;
            end
            CmdExpire: begin
              state_d = StScan;
              cnt_d   = '0;
              next_d  = TimeMax;
            end
            default: ;
          endcase
        end
      end

      StScan: begin
        // Issue stage: read the next entry.
        if (cnt_q < CntBits'(NumTimers)) begin
          rd_en      = 1'b1;
          pipe_vld_d = 1'b1;
          cnt_d      = cnt_q + CntBits'(1);
        end else begin
          state_d = StDone;
        end
        // Update stage: the entry read in the previous cycle.
        if (pipe_vld_q && armed_q[pipe_idx_q]) begin
          if (rdata.remaining <= sleep_q) begin
            out_vld_d      = 1'b1;
            out_d.kind     = KindFired;
            out_d.index    = pipe_idx_q;
            out_d.fired_id = rdata.owner;
            if (rdata.period == '0) begin
              armed_d[pipe_idx_q] = 1'b0;
            end else begin
              mem_we              = 1'b1;
              mem_wdata.remaining = rdata.period;
              cand                = rdata.period;
              keep                = 1'b1;
            end
          end else begin
            mem_we              = 1'b1;
            mem_wdata.remaining = rdata.remaining - sleep_q;
            cand                = rdata.remaining - sleep_q;
            keep                = 1'b1;
          end
          if (keep && (cand < next_q)) begin
            next_d = cand;
          end
        end
      end

      StDone: begin
        sleep_d     = next_q;
        out_vld_d   = 1'b1;
        out_d.kind  = KindDone;
        out_d.prog  = 1'b1;
        out_d.value = next_q;
        out_d.last  = 1'b1;
        state_d     = StIdle;
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q    <= '0;
      sleep_q    <= TimeMax;
      cnt_q      <= '0;
      pipe_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      armed_q    <= armed_d;
      sleep_q    <= sleep_d;
      cnt_q      <= cnt_d;
      pipe_vld_q <= pipe_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    next_q     <= next_d;
    pipe_idx_q <= pipe_idx_d;
    out_q      <= out_d;
  end

  assign result_valid_o  = out_vld_q;
  assign result_kind_o   = out_q.kind;
  assign entry_index_o   = out_q.index;
  assign fired_id_o      = out_q.fired_id;
  assign program_alarm_o = out_q.prog;
  assign alarm_value_o   = out_q.value;
  assign last_o          = out_q.last;

  // The write-back never targets the entry being read in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && pipe_vld_q) |-> (pipe_idx_q != cnt_q[IdxBits-1:0]))
    else $error("read and write-back hit the same entry");

  // Only fired-alarm transactions are not the final one of a command.
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (out_q.kind != KindFired)) |-> out_q.last)
    else $error("non-fire result without last");

  // The closing state always produces the summary transaction and goes idle.
  a_done_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) |=> (state_q == StIdle && out_vld_q && out_q.kind == KindDone))
    else $error("expiry summary missing");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntBits'(NumTimers))
    else $error("scan counter out of range");

endmodule
`default_nettype wire
